// File: rtl/u8e_pkg.sv
// ----------------------------------------------------------------------------
// u8e_pkg: shared types and constants of the UTF-8 code point encoder
// Holds the byte cell type, the sequence tables and the encode function.
// ----------------------------------------------------------------------------
package u8e_pkg;

    localparam int unsigned SEQ_MAX = 6;

    typedef logic [2:0] seq_len_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       valid;
    } cell_t;

    typedef cell_t [SEQ_MAX-1:0] seq_t;

    // Replacement character U+FFFD for a code point with bit 31 set
    localparam logic [7:0] REPL_BYTE0 = 8'hEF;
    localparam logic [7:0] REPL_BYTE1 = 8'hBF;
    localparam logic [7:0] REPL_BYTE2 = 8'hBD;

    localparam logic [7:0] CONT_PREFIX = 8'h80;
    localparam logic [7:0] CONT_MASK   = 8'h3F;

    // Indexed by sequence length
    localparam logic [7:0] LEAD_PREFIX [7] = '{8'h00, 8'h00, 8'hC0, 8'hE0,
                                               8'hF0, 8'hF8, 8'hFC};
    localparam logic [7:0] LEAD_MASK   [7] = '{8'h00, 8'h7F, 8'h1F, 8'h0F,
                                               8'h07, 8'h03, 8'h01};
    // Shift of the payload bits that land in the lead byte: 6 * (len - 1)
    localparam logic [4:0] LEAD_SHIFT  [7] = '{5'd0, 5'd0, 5'd6, 5'd12,
                                               5'd18, 5'd24, 5'd30};

    // Build the full byte sequence of one code point, lead byte in cell 0
    function automatic seq_t encode(input logic [31:0] cp);
        seq_t     r;
        seq_len_t n;
        seq_len_t idx;
        r = '0;
        if (cp[31])
        begin
            r[0] = '{data: REPL_BYTE0, last: 1'b0, valid: 1'b1};
            r[1] = '{data: REPL_BYTE1, last: 1'b0, valid: 1'b1};
            r[2] = '{data: REPL_BYTE2, last: 1'b1, valid: 1'b1};
        end
        else
        begin
            if (cp[30:26] != '0)
                n = 3'd6;
            else if (cp[25:21] != '0)
                n = 3'd5;
            else if (cp[20:16] != '0)
                n = 3'd4;
            else if (cp[15:11] != '0)
                n = 3'd3;
            else if (cp[10:7] != '0)
                n = 3'd2;
            else
                n = 3'd1;
            r[0].data  = LEAD_PREFIX[n] | (8'(cp >> LEAD_SHIFT[n]) & LEAD_MASK[n]);
            r[0].last  = (n == 3'd1);
            r[0].valid = 1'b1;
            for (int k = 1; k < SEQ_MAX; k++)
            begin
                if (3'(k) < n)
                begin
                    // 6 * (n - 1 - k) equals the lead shift of length n - k
                    idx        = 3'(n - 3'(k));
                    r[k].data  = CONT_PREFIX | (8'(cp >> LEAD_SHIFT[idx]) & CONT_MASK);
                    r[k].last  = (3'(k) == 3'(n - 3'd1));
                    r[k].valid = 1'b1;
                end
            end
        end
        return r;
    endfunction

endpackage

// File: rtl/u8e_cell.sv
// ----------------------------------------------------------------------------
// u8e_cell: one byte cell of the output chain
// Loads one byte of a new sequence or takes its neighbor's byte on a shift.
// ----------------------------------------------------------------------------
module u8e_cell
    import u8e_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  load,
    input  logic  shift,
    input  cell_t load_cell,
    input  cell_t neighbor,
    output cell_t cell_q
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic [7:0] data_next;
    logic       last_reg;
    logic       last_next;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = load_cell.valid;
            data_next  = load_cell.data;
            last_next  = load_cell.last;
        end
        else if (shift)
        begin
            valid_next = neighbor.valid;
            data_next  = neighbor.data;
            last_next  = neighbor.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign cell_q = '{data: data_reg, last: last_reg, valid: valid_reg};

endmodule

// File: rtl/u8e_in_stage.sv
// ----------------------------------------------------------------------------
// u8e_in_stage: input holding register and byte sequence encoder
// Holds one code point until the chain is free and presents its bytes.
// ----------------------------------------------------------------------------
module u8e_in_stage
    import u8e_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [31:0] in_data,
    input  logic        load,
    output logic        in_ready,
    output logic        held_valid,
    output seq_t        seq
);

    logic        valid_reg;
    logic        valid_next;
    logic [31:0] cp_reg;
    logic        accept;

    assign in_ready = !valid_reg || load;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (load)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            cp_reg <= in_data;
    end

    assign held_valid = valid_reg;
    assign seq        = encode(cp_reg);

endmodule

// File: rtl/utf8_code_point_encoder.sv
// ----------------------------------------------------------------------------
// utf8_code_point_encoder: UTF-8 encoder in the original six-byte form
// Turns one 32-bit code point per transaction into 1 to 6 UTF-8 bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side (s_axis_*) takes one code point per transaction on tdata.
//   Master side (m_axis_*) gives one byte per transaction on tdata, lead byte
//   first, with tlast high on the final byte of each code point.
//   The length follows the highest set bit (1 to 6 bytes, no surrogate check).
//   A code point with bit 31 set comes out as U+FFFD, bytes EF BF BD.
// Path: an accepted code point is held in the input holding register, then
//   loaded into the byte chain that drives m_axis.
// Throughput: one byte per cycle while m_axis_tready is high, set by the
//   output chain that drains one cell per cycle; single-byte characters
//   stream at one per cycle.
// Reset: clears the valid flags of the holding register and all cells; no clearing pass.
// Stall: with m_axis_tready low the chain holds; the input register still
//   takes one more code point, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module utf8_code_point_encoder
    import u8e_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] code_point
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast    // last_byte
);

    seq_t  seq;
    cell_t chain [SEQ_MAX+1];
    logic  held_valid;
    logic  take;
    logic  chain_free;
    logic  load;

    // Advance the chain whenever the head byte leaves
    assign take       = chain[0].valid && m_axis_tready;
    // The chain is free for a new sequence when empty or once only the last byte is leaving
    assign chain_free = !chain[0].valid || (m_axis_tready && !chain[1].valid);
    assign load       = held_valid && chain_free;

    u8e_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_data    (s_axis_tdata),
        .load       (load),
        .in_ready   (s_axis_tready),
        .held_valid (held_valid),
        .seq        (seq)
    );

    // Feed zeros into the tail of the chain
    assign chain[SEQ_MAX] = '0;

    for (genvar i = 0; i < SEQ_MAX; i++)
    begin : g_cell
        u8e_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .load      (load),
            .shift     (take),
            .load_cell (seq[i]),
            .neighbor  (chain[i+1]),
            .cell_q    (chain[i])
        );
    end

    assign m_axis_tvalid = chain[0].valid;
    assign m_axis_tdata  = chain[0].data;
    assign m_axis_tlast  = chain[0].last;

endmodule

// File: dv/tb_utf8_code_point_encoder.sv
// ----------------------------------------------------------------------------
// tb_utf8_code_point_encoder: self-checking bench of the UTF-8 encoder
// Streams code points into the encoder with random gaps and output stalls.
// Every transaction is predicted as its UTF-8 byte sequence, and each byte
// that leaves the encoder is checked against the oldest expected byte.
// ----------------------------------------------------------------------------
module tb_utf8_code_point_encoder;

    // Replacement character U+FFFD, sent for any code point with bit 31 set
    localparam logic [7:0] FFFD_BYTE0 = 8'hEF;
    localparam logic [7:0] FFFD_BYTE1 = 8'hBF;
    localparam logic [7:0] FFFD_BYTE2 = 8'hBD;
    localparam logic [7:0] CONT_TAG   = 8'h80;
    localparam logic [7:0] CONT_BITS  = 8'h3F;

    localparam int RANDOM_ITEMS  = 500;
    localparam int IDLE_PCT      = 35;
    // Sender runs gap-free over this range of transactions
    localparam int BURST_FIRST   = 250;
    localparam int BURST_LAST    = 330;
    // Receiver runs stall-free over this range of bytes
    localparam int FLOW_FIRST    = 800;
    localparam int FLOW_LAST     = 1100;
    // Long receiver hold-off that backs the encoder up into its input
    localparam int HOLD_AT_BYTE  = 400;
    localparam int HOLD_CYCLES   = 200;
    localparam int DRAIN_CYCLES  = 20;
    localparam int LIMIT_CYCLES  = 400000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } utf8_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    logic [31:0] code_point_q [$];     // code points waiting to be sent
    utf8_byte_t  utf8_byte_q [$];      // bytes the encoder still owes us
    int          items_sent = 0;
    int          bytes_seen = 0;
    int          error_count = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    utf8_code_point_encoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Append the UTF-8 sequence of one code point to the expected bytes.
    // The length follows the highest set bit; the lead byte carries a run of
    // len ones followed by a zero, then the top payload bits.
    function automatic void push_utf8_bytes(input logic [31:0] cp);
        int         len;
        int         shift;
        logic [7:0] lead_tag;
        logic [7:0] lead_bits;
        utf8_byte_t b;
        if (cp[31])
        begin
            utf8_byte_q.push_back('{data: FFFD_BYTE0, last: 1'b0});
            utf8_byte_q.push_back('{data: FFFD_BYTE1, last: 1'b0});
            utf8_byte_q.push_back('{data: FFFD_BYTE2, last: 1'b1});
            return;
        end
        if (cp <= 32'h0000_007F)
            len = 1;
        else if (cp <= 32'h0000_07FF)
            len = 2;
        else if (cp <= 32'h0000_FFFF)
            len = 3;
        else if (cp <= 32'h001F_FFFF)
            len = 4;
        else if (cp <= 32'h03FF_FFFF)
            len = 5;
        else
            len = 6;
        if (len == 1)
        begin
            utf8_byte_q.push_back('{data: cp[7:0], last: 1'b1});
            return;
        end
        lead_tag  = ~(8'hFF >> len);
        lead_bits = 8'hFF >> (len + 1);
        shift     = 6 * (len - 1);
        b.data    = lead_tag | (8'(cp >> shift) & lead_bits);
        b.last    = 1'b0;
        utf8_byte_q.push_back(b);
        for (int k = 1; k < len; k++)
        begin
            shift  = 6 * (len - 1 - k);
            b.data = CONT_TAG | (8'(cp >> shift) & CONT_BITS);
            b.last = (k == len - 1);
            utf8_byte_q.push_back(b);
        end
    endfunction

    // Random code point: mostly one per length class, plus invalid values
    // and fully random words so that every input bit toggles.
    function automatic logic [31:0] random_code_point();
        logic [31:0] cp;
        case ($urandom_range(7, 0))
            0: cp = $urandom_range(32'h0000_007F, 32'h0000_0000);
            1: cp = $urandom_range(32'h0000_07FF, 32'h0000_0080);
            2: cp = $urandom_range(32'h0000_FFFF, 32'h0000_0800);
            3: cp = $urandom_range(32'h001F_FFFF, 32'h0001_0000);
            4: cp = $urandom_range(32'h03FF_FFFF, 32'h0020_0000);
            5: cp = $urandom_range(32'h7FFF_FFFF, 32'h0400_0000);
            6: cp = $urandom() | 32'h8000_0000;
            default: cp = $urandom();
        endcase
        return cp;
    endfunction

    // Driver: hold a transaction until taken, then fetch the next code point
    // or leave a random gap. Predict each code point as it is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                push_utf8_bytes(s_axis_tdata);
                items_sent++;
            end
            if (s_axis_tvalid && !s_axis_tready)
            begin
                // hold the current transaction
            end
            else if (code_point_q.size() != 0 &&
                     ((items_sent >= BURST_FIRST && items_sent < BURST_LAST) ||
                      $urandom_range(99, 0) >= IDLE_PCT))
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= code_point_q.pop_front();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Monitor: check each byte against the oldest expected one, then pick
    // the next ready value (long hold-off once, a stall-free stretch, and
    // random stalls elsewhere).
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (utf8_byte_q.size() == 0)
                begin
                    $display("%0t: unexpected byte %02h last %0b", $time,
                             m_axis_tdata, m_axis_tlast);
                    error_count++;
                end
                else
                begin
                    if (m_axis_tdata !== utf8_byte_q[0].data)
                    begin
                        $display("%0t: out_byte expected %02h actual %02h", $time,
                                 utf8_byte_q[0].data, m_axis_tdata);
                        error_count++;
                    end
                    if (m_axis_tlast !== utf8_byte_q[0].last)
                    begin
                        $display("%0t: last_byte expected %0b actual %0b", $time,
                                 utf8_byte_q[0].last, m_axis_tlast);
                        error_count++;
                    end
                    void'(utf8_byte_q.pop_front());
                end
                bytes_seen++;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!hold_done && bytes_seen >= HOLD_AT_BYTE)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end
            else if (bytes_seen >= FLOW_FIRST && bytes_seen < FLOW_LAST)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(99, 0) >= IDLE_PCT);
        end
    end

    // Stimulus and end of run
    initial
    begin
        // Length boundaries, invalid values and a few notable characters
        code_point_q.push_back(32'h0000_0000);   // NUL is an ordinary character
        code_point_q.push_back(32'h0000_007F);
        code_point_q.push_back(32'h0000_0080);
        code_point_q.push_back(32'h0000_07FF);
        code_point_q.push_back(32'h0000_0800);
        code_point_q.push_back(32'h0000_D800);   // surrogate, no check
        code_point_q.push_back(32'h0000_FFFD);
        code_point_q.push_back(32'h0000_FFFF);
        code_point_q.push_back(32'h0001_0000);
        code_point_q.push_back(32'h0010_FFFF);
        code_point_q.push_back(32'h0011_0000);   // past the modern limit
        code_point_q.push_back(32'h001F_FFFF);
        code_point_q.push_back(32'h0020_0000);
        code_point_q.push_back(32'h03FF_FFFF);
        code_point_q.push_back(32'h0400_0000);
        code_point_q.push_back(32'h2AAA_AAAA);
        code_point_q.push_back(32'h5555_5555);
        code_point_q.push_back(32'h7FFF_FFFF);
        code_point_q.push_back(32'h8000_0000);   // invalid, smallest negative
        code_point_q.push_back(32'hAAAA_AAAA);
        code_point_q.push_back(32'hFFFF_FFFF);
        for (int i = 0; i < RANDOM_ITEMS; i++)
            code_point_q.push_back(random_code_point());

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // drain: all sent, nothing in flight, nothing owed
        while (code_point_q.size() != 0 || s_axis_tvalid || utf8_byte_q.size() != 0)
            @(posedge clk);
        // let any stray extra bytes show up
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(12 * LIMIT_CYCLES);
        $display("simulation failed");
        $finish;
    end

endmodule
